/* rtl/wrapped_angle_velocity_estimator_unit_assert.svh */
// Assertion macros used by the controller of the angle velocity estimator.
// Depends on nothing; the including module must provide clk and rst.
`ifndef WRAPPED_ANGLE_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH
`define WRAPPED_ANGLE_VELOCITY_ESTIMATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WAVE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WAVE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wave_pkg.sv */
// Shared types and constants of the wrapped angle velocity estimator.
// Used by the controller, the datapath and the top level.
package wave_pkg;

  localparam int AngleW = 12;
  localparam int RawW   = 16;
  localparam int TimeW  = 32;
  localparam int AccW   = 32;
  localparam int DiffW  = AngleW + 1;
  localparam int ScaleW = 27;
  localparam int MagW   = 32;
  localparam int ProdW  = MagW + ScaleW;
  localparam int AddrW  = 2;

  // Half a turn and the bit pattern of a full turn on the 4096-count circle.
  localparam logic signed [DiffW-1:0] HalfTurn = 13'sd2048;
  localparam logic [DiffW-1:0]        FullTurn = 13'h1000;

  // round(2*pi/4096 * 1e6 * 65536): counts per microsecond to Q16.16 rad/s.
  localparam logic [ScaleW-1:0] VelScale = 27'd100530965;

  localparam logic [TimeW-1:0] WindowReset = 32'd10000;
  localparam logic [AddrW-1:0] AddrWindow  = 2'd0;

  typedef struct packed {
    logic             read_ok;
    logic [RawW-1:0]  raw_word;
    logic [TimeW-1:0] now_us;
  } in_t;

  typedef struct packed {
    logic                    data_valid;
    logic [RawW-1:0]         last_raw;
    logic [AngleW-1:0]       angle_counts;
    logic signed [AccW-1:0]  velocity_q16;
    logic                    velocity_updated;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic mul_load;
    logic div_start;
    logic vel_write;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic vel_needed;
    logic div_done;
  } ctrl_sts_t;

endpackage

/* rtl/wrapped_angle_velocity_estimator_unit.sv */
// Each accepted word passes the update state, then the output state; a word
// with a velocity update also passes multiply, divider start, the bit-serial
// 59-step divider and saturation in between. Words are taken one at a time.
// A finished result waits in an output register while the next word is taken.
// Reset (rst, synchronous, active high) clears all tracking state and sets
// window_us to 10000.
module wrapped_angle_velocity_estimator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  wave_pkg::in_t                 sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output wave_pkg::out_t                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wave_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [wave_pkg::TimeW-1:0] window_us;
  wave_pkg::ctrl_cmd_t        cmd;
  wave_pkg::ctrl_sts_t        sts;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_us <= wave_pkg::WindowReset;
    end else if (psel && penable && pwrite && paddr == wave_pkg::AddrWindow) begin
      window_us <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == wave_pkg::AddrWindow) ? window_us : 32'd0;

  wave_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  wave_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .window_us (window_us),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

endmodule

/* rtl/wave_div.sv */
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Self-contained; parameterized by dividend and divisor widths.
module wave_div #(
  parameter int NumW = 59,
  parameter int DenW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quot
);

  localparam int CntW = $clog2(NumW);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [DenW-1:0] rem;
  logic [NumW-1:0] quo;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_sh;
  logic            fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh = {rem, quo[NumW-1]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and the shared dividend and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      quo <= {quo[NumW-2:0], fits};
    end
  end

  assign quot = quo;

endmodule

/* rtl/wave_dp.sv */
// Datapath of the angle velocity estimator: tracking state, multiply, divide
// and result register. Depends on wave_pkg and wave_div.
module wave_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  wave_pkg::in_t                  sample,
  input  logic [wave_pkg::TimeW-1:0]     window_us,
  input  wave_pkg::ctrl_cmd_t            cmd,
  output wave_pkg::ctrl_sts_t            sts,
  output wave_pkg::out_t                 result
);

  localparam int AccW   = wave_pkg::AccW;
  localparam int AngleW = wave_pkg::AngleW;
  localparam int DiffW  = wave_pkg::DiffW;
  localparam int ProdW  = wave_pkg::ProdW;
  localparam int MagW   = wave_pkg::MagW;
  localparam int TimeW  = wave_pkg::TimeW;

  wave_pkg::in_t               samp_q;
  logic                        seeded;
  logic                        valid_flag;
  logic [wave_pkg::RawW-1:0]   raw_hold;
  logic [AngleW-1:0]           prev_angle;
  logic signed [AccW-1:0]      delta_sum;
  logic [TimeW-1:0]            window_start;
  logic signed [AccW-1:0]      velocity_hold;
  logic                        updated;
  logic                        acc_neg;
  logic [MagW-1:0]             mag;
  logic [TimeW-1:0]            elapsed_q;
  logic [ProdW-1:0]            product;
  wave_pkg::out_t              result_q;

  logic [AngleW-1:0]           angle;
  logic signed [DiffW-1:0]     diff;
  logic signed [DiffW-1:0]     d_wrap;
  logic signed [AccW:0]        sum_wide;
  logic signed [AccW-1:0]      sum_sat;
  logic [TimeW-1:0]            elapsed;
  logic                        win_hit;
  logic                        div_done;
  logic [ProdW-1:0]            quot;
  logic [AccW-1:0]             vel_sat;

  // Wrapped angle change and the saturating accumulator.
  always_comb begin
    angle = samp_q.raw_word[AngleW-1:0];
    diff  = $signed({1'b0, angle}) - $signed({1'b0, prev_angle});
    // Adding the full-turn pattern is a subtract of 4096 above half a turn and
    // an add of 4096 below minus half a turn: both are equal modulo 8192.
    if (diff > wave_pkg::HalfTurn || diff < -wave_pkg::HalfTurn) begin
      d_wrap = diff + $signed(wave_pkg::FullTurn);
    end else begin
      d_wrap = diff;
    end
    sum_wide = (AccW + 1)'(delta_sum) + (AccW + 1)'(d_wrap);
    if (sum_wide[AccW] != sum_wide[AccW-1]) begin
      sum_sat = sum_wide[AccW] ? {1'b1, {(AccW - 1){1'b0}}} : {1'b0, {(AccW - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[AccW-1:0];
    end
    elapsed = samp_q.now_us - window_start;
    win_hit = elapsed >= window_us;
  end

  assign sts.vel_needed = samp_q.read_ok && seeded && win_hit && (elapsed != '0);
  assign sts.div_done   = div_done;

  // Captured input word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      samp_q <= sample;
    end
  end

  // Tracking state, updated once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded        <= 1'b0;
      valid_flag    <= 1'b0;
      raw_hold      <= '0;
      prev_angle    <= '0;
      delta_sum     <= '0;
      window_start  <= '0;
      velocity_hold <= '0;
      updated       <= 1'b0;
    end else if (cmd.update) begin
      updated <= sts.vel_needed;
      if (!samp_q.read_ok) begin
        valid_flag <= 1'b0;
      end else begin
        raw_hold   <= samp_q.raw_word;
        valid_flag <= 1'b1;
        prev_angle <= angle;
        if (!seeded) begin
          seeded        <= 1'b1;
          window_start  <= samp_q.now_us;
          delta_sum     <= '0;
          velocity_hold <= '0;
        end else if (win_hit) begin
          delta_sum    <= '0;
          window_start <= samp_q.now_us;
        end else begin
          delta_sum <= sum_sat;
        end
      end
    end else if (cmd.vel_write) begin
      velocity_hold <= vel_sat;
    end
  end

  // Operands of the velocity computation.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      acc_neg   <= sum_sat[AccW-1];
      mag       <= sum_sat[AccW-1] ? (~sum_sat + 1'b1) : sum_sat;
      elapsed_q <= elapsed;
    end
    if (cmd.mul_load) begin
      product <= ProdW'(mag) * ProdW'(wave_pkg::VelScale);
    end
  end

  // Serial division of the scaled count by the elapsed time.
  wave_div #(
    .NumW (ProdW),
    .DenW (TimeW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (product),
    .den   (elapsed_q),
    .done  (div_done),
    .quot  (quot)
  );

  // Sign inversion and saturation to 32 bits.
  always_comb begin
    if (acc_neg) begin
      vel_sat = (quot[ProdW-1:AccW-1] != '0) ? {1'b0, {(AccW - 1){1'b1}}}
                                              : quot[AccW-1:0];
    end else if (quot[ProdW-1:AccW] != '0 ||
                 (quot[AccW-1] && quot[AccW-2:0] != '0)) begin
      vel_sat = {1'b1, {(AccW - 1){1'b0}}};
    end else begin
      vel_sat = ~quot[AccW-1:0] + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_q.data_valid       <= valid_flag;
      result_q.last_raw         <= raw_hold;
      result_q.angle_counts     <= raw_hold[AngleW-1:0];
      result_q.velocity_q16     <= velocity_hold;
      result_q.velocity_updated <= updated;
    end
  end

  assign result = result_q;

endmodule

/* rtl/wave_ctrl.sv */
// Controller of the angle velocity estimator: sequences one word at a time.
// Depends on wave_pkg and the assertion macro header.
`include "wrapped_angle_velocity_estimator_unit_assert.svh"

module wave_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  wave_pkg::ctrl_sts_t  sts,
  output wave_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIVGO  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_SAT    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;

  assign sample_ready = (state == S_IDLE);
  assign result_valid = out_valid;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.vel_needed ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        cmd.vel_write = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || result_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and result word flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `WAVE_ASSERT_NXT(a_accept_updates, sample_valid && sample_ready, state == S_UPDATE, "accepted word not processed")
  `WAVE_ASSERT_NXT(a_div_waits, state == S_DIV && !sts.div_done, state == S_DIV, "left divide before done")
  `WAVE_ASSERT_IMP(a_out_slot_free, cmd.out_load, !out_valid || result_ready, "result word overwritten")

endmodule
